// ----- src/tcw_pkg.sv -----
// shared types and constants for the text console character writer
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_SETPOS = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;

  localparam logic [7:0]  RESET_ATTR = 8'h0F;
  localparam logic [15:0] RESET_CELL = {RESET_ATTR, BLANK_CHAR};
  localparam int          TAB_STOP   = 8;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  char_code;
    logic [6:0]  column_in;
    logic [4:0]  row_in;
    logic [10:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [10:0] cursor_position;
  } res_t;

endpackage

// ----- src/tcw_screen_ram.sv -----
// screen cell store: one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module tcw_screen_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [15:0]       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [15:0]       rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/text_console_char_writer_core.sv -----
// text console engine: cursor control, screen writes, scroll and clear sweeps
// depends on tcw_pkg and tcw_screen_ram
`timescale 1ns / 1ps
// put char, set cursor, read cell: S_EXEC, then S_DONE loads the result register; no new
// item is taken before S_IDLE. a put char past the last row adds a scroll sweep (S_PRIME, S_SCROLL),
// one memory cell moved per cycle through the single read/write port pair.
// clear screen adds a blanking sweep, one cell per cycle.
// after rst the screen is blanked by an init pass over every cell with no item
// accepted; attribute writes are taken during it. cursor resets to 0, attribute to 0x0F.

module text_console_char_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  tcw_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output tcw_pkg::res_t res,
  input  logic          attr_wr_en,
  input  logic [7:0]    attr_wr_data
);

  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS + TAB_STOP);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int FULL_W = ($clog2(CELLS + 1) > 11) ? $clog2(CELLS + 1) : 11;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_CLEAR  = 3'd3;
  localparam logic [2:0] S_PRIME  = 3'd4;
  localparam logic [2:0] S_SCROLL = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]        state, state_next;
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic [7:0]        attr;
  cmd_t              item;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata, mem_rdata;

  logic [15:0]       blank;
  logic [COL_W-1:0]  col_calc, wcol, tab_col;
  logic [ROW_W-1:0]  row_calc;
  logic              do_write;
  logic [FULL_W-1:0] wr_pos, cur_pos;
  logic [ADDR_W:0]   scroll_rd;
  logic              idx_ok;

  tcw_screen_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign blank     = {attr, BLANK_CHAR};
  assign cmd_ready = (state == S_IDLE);
  assign tab_col   = (cur_col + COL_W'(TAB_STOP)) & ~COL_W'(TAB_STOP - 1);
  assign scroll_rd = {1'b0, ptr} + (ADDR_W + 1)'(COLUMNS + 1);
  assign idx_ok    = FULL_W'(item.cell_index) < FULL_W'(CELLS);
  assign cur_pos   = FULL_W'(cur_row) * FULL_W'(COLUMNS) + FULL_W'(cur_col);

  // mode 0 cursor update and cell write
  always_comb begin
    col_calc = cur_col;
    row_calc = cur_row;
    wcol     = cur_col;
    do_write = 1'b0;
    case (item.char_code)
      CH_NEWLINE: begin
        col_calc = '0;
        row_calc = cur_row + ROW_W'(1);
      end
      CH_RETURN: begin
        col_calc = '0;
      end
      CH_BACKSPACE: begin
        if (cur_col != '0) begin
          col_calc = cur_col - COL_W'(1);
          wcol     = cur_col - COL_W'(1);
          do_write = 1'b1;
        end
      end
      CH_TAB: begin
        if (tab_col >= COL_W'(COLUMNS)) begin
          col_calc = '0;
          row_calc = cur_row + ROW_W'(1);
        end else begin
          col_calc = tab_col;
        end
      end
      default: begin
        do_write = 1'b1;
        if (cur_col + COL_W'(1) >= COL_W'(COLUMNS)) begin
          col_calc = '0;
          row_calc = cur_row + ROW_W'(1);
        end else begin
          col_calc = cur_col + COL_W'(1);
        end
      end
    endcase
  end

  assign wr_pos = FULL_W'(cur_row) * FULL_W'(COLUMNS) + FULL_W'(wcol);

  always_comb begin
    state_next   = state;
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    ptr_next     = ptr;
    mem_we       = 1'b0;
    mem_waddr    = ptr;
    mem_wdata    = blank;
    mem_re       = 1'b0;
    mem_raddr    = ptr;
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_CELL;
        ptr_next  = ptr + ADDR_W'(1);
        if (ptr == ADDR_W'(CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (item.mode)
          MODE_PUT: begin
            mem_we    = do_write;
            mem_waddr = wr_pos[ADDR_W-1:0];
            mem_wdata = (item.char_code == CH_BACKSPACE) ? blank : {attr, item.char_code};
            cur_col_next = col_calc;
            if (row_calc >= ROW_W'(ROWS)) begin
              cur_row_next = ROW_W'(ROWS - 1);
              state_next   = S_PRIME;
            end else begin
              cur_row_next = row_calc;
            end
          end
          MODE_SETPOS: begin
            cur_col_next = ({2'b0, item.column_in} >= 9'(COLUMNS)) ?
                           COL_W'(COLUMNS - 1) : COL_W'(item.column_in);
            cur_row_next = ({2'b0, item.row_in} >= 7'(ROWS)) ?
                           ROW_W'(ROWS - 1) : ROW_W'(item.row_in);
          end
          MODE_CLEAR: begin
            cur_col_next = '0;
            cur_row_next = '0;
            ptr_next     = '0;
            state_next   = S_CLEAR;
          end
          default: begin
            mem_re    = idx_ok;
            mem_raddr = FULL_W'(item.cell_index) >= FULL_W'(CELLS) ? '0 :
                        ADDR_W'(item.cell_index);
          end
        endcase
      end
      S_CLEAR: begin
        mem_we   = 1'b1;
        ptr_next = ptr + ADDR_W'(1);
        if (ptr == ADDR_W'(CELLS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_PRIME: begin
        // first read of the row below, sweep pointer at cell 0
        mem_re     = 1'b1;
        mem_raddr  = ADDR_W'(COLUMNS);
        ptr_next   = '0;
        state_next = S_SCROLL;
      end
      S_SCROLL: begin
        // read one row ahead while the previous read lands one row up
        mem_we    = 1'b1;
        mem_wdata = (ptr < ADDR_W'(CELLS - COLUMNS)) ? mem_rdata : blank;
        mem_re    = scroll_rd < (ADDR_W + 1)'(CELLS);
        mem_raddr = scroll_rd[ADDR_W-1:0];
        ptr_next  = ptr + ADDR_W'(1);
        if (ptr == ADDR_W'(CELLS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_valid || res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      cur_col <= '0;
      cur_row <= '0;
      ptr     <= '0;
      attr    <= RESET_ATTR;
    end else begin
      state   <= state_next;
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      ptr     <= ptr_next;
      if (attr_wr_en) begin
        attr <= attr_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      item <= cmd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && (!res_valid || res_ready)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!res_valid || res_ready)) begin
      res.cell_value      <= (item.mode == MODE_READ && idx_ok) ? mem_rdata : 16'd0;
      res.cursor_position <= cur_pos[10:0];
    end
  end

endmodule
